@@ rtl/core/first_fit_segment_allocator_unit_defines.svh @@
// assertion macros for the first-fit segment allocator checker
// depends on nothing; expects clk and rst_n in the scope of each use
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define FFSA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffsa assertion failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define FFSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffsa assertion failed");

`endif

@@ rtl/core/ffsa_pkg.sv @@
// shared types, constants and codes of the first-fit segment allocator
// depends on nothing; imported by every module of the block
package ffsa_pkg;

    // field widths
    localparam int OP_W       = 1;
    localparam int SIZE_W     = 21;
    localparam int BASE_W     = 20;
    localparam int STATUS_W   = 2;
    localparam int START_W    = 20;
    localparam int MEM_SIZE_W = 21;

    // defaults for the top level parameters
    localparam int FFSA_MAX_SEGMENTS = 16;
    localparam int FFSA_ADDR_BITS    = 20;

    // reset value of the memory size register
    localparam logic [MEM_SIZE_W-1:0] MEM_SIZE_RESET = 21'd1048576;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOROOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    // input word
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] size;
        logic [BASE_W-1:0] base;
    } ffsa_in_t;

    // output word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  seg_start;
    } ffsa_out_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_TAIL,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_RESP
    } ffsa_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic                load;
        logic                scan;
        logic                set_hit;
        logic                set_tail;
        logic                ins_rd;
        logic                ins_wr;
        logic                ins_new;
        logic                del_rd;
        logic                del_wr;
        logic                del_done;
        logic                res_set;
        logic [STATUS_W-1:0] res_status;
        logic                out_load;
    } ffsa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_rel;
        logic reject;
        logic empty;
        logic hit;
        logic last;
        logic tail_fit;
        logic k_at_pos;
        logic k_at_end;
    } ffsa_stat_t;

endpackage

@@ rtl/core/ffsa_ctrl.sv @@
// controller state machine of the first-fit segment allocator
// depends on ffsa_pkg; drives ffsa_dp through command and status structs
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  ffsa_stat_t stat,
    output ffsa_cmd_t  cmd
);

    ffsa_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // state register and output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.is_rel && stat.reject)
                    state_next = S_RESP;
                else if (stat.empty)
                    state_next = stat.is_rel ? S_RESP : S_TAIL;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.hit)
                    state_next = stat.is_rel ? S_DEL_RD : S_INS_RD;
                else if (stat.last)
                    state_next = stat.is_rel ? S_RESP : S_TAIL;
            end
            S_TAIL:
            begin
                state_next = stat.tail_fit ? S_INS_RD : S_RESP;
            end
            S_INS_RD:
            begin
                state_next = stat.k_at_pos ? S_RESP : S_INS_WR;
            end
            S_INS_WR:
            begin
                state_next = S_INS_RD;
            end
            S_DEL_RD:
            begin
                state_next = stat.k_at_end ? S_RESP : S_DEL_WR;
            end
            S_DEL_WR:
            begin
                state_next = S_DEL_RD;
            end
            S_RESP:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands and handshake outputs
    always_comb
    begin
        cmd            = '0;
        cmd.res_status = ST_OK;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_CHECK:
            begin
                if (!stat.is_rel && stat.reject)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NOROOM;
                end
                else if (stat.empty && stat.is_rel)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NOTFOUND;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                    cmd.set_hit = 1'b1;
                else
                begin
                    cmd.scan = 1'b1;
                    if (stat.last && stat.is_rel)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_NOTFOUND;
                    end
                end
            end
            S_TAIL:
            begin
                if (stat.tail_fit)
                    cmd.set_tail = 1'b1;
                else
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NOROOM;
                end
            end
            S_INS_RD:
            begin
                if (stat.k_at_pos)
                begin
                    cmd.ins_new    = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                end
                else
                    cmd.ins_rd = 1'b1;
            end
            S_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
            end
            S_DEL_RD:
            begin
                if (stat.k_at_end)
                begin
                    cmd.del_done   = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                end
                else
                    cmd.del_rd = 1'b1;
            end
            S_DEL_WR:
            begin
                cmd.del_wr = 1'b1;
            end
            S_RESP:
            begin
                cmd.out_load = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // output word valid: set on load, cleared when taken
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/ffsa_dp.sv @@
// datapath of the first-fit segment allocator: segment memory, scan and result
// depends on ffsa_pkg; commanded by ffsa_ctrl
module ffsa_dp
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = FFSA_MAX_SEGMENTS,
    parameter int ADDR_BITS    = FFSA_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffsa_in_t              in_data,
    output ffsa_out_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [MEM_SIZE_W-1:0] cfg_wr_data,
    input  ffsa_cmd_t             cmd,
    output ffsa_stat_t            stat
);

    localparam int IW   = $clog2(MAX_SEGMENTS);
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int CURW = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 2;
    localparam int EW   = ADDR_BITS + SIZE_W;
    localparam logic [CURW-1:0] SPACE     = CURW'(1) << ADDR_BITS;
    localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(MAX_SEGMENTS);

    // segment memory: {base, length} per slot, sorted by base
    logic [EW-1:0]         seg_mem_reg [MAX_SEGMENTS];
    logic [EW-1:0]         rd_data_reg;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;

    logic [OP_W-1:0]       op_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [BASE_W-1:0]     base_reg;
    logic [CURW-1:0]       cursor_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         k_reg;
    logic [IW-1:0]         pos_reg;
    logic [CNTW-1:0]       count_reg;
    logic [MEM_SIZE_W-1:0] mem_size_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [START_W-1:0]    start_reg;
    ffsa_out_t             out_data_reg;

    logic [ADDR_BITS-1:0]  rd_base;
    logic [SIZE_W-1:0]     rd_len;
    logic [CURW-1:0]       rd_base_ext;
    logic [CURW-1:0]       size_ext;
    logic [CURW-1:0]       seg_end;
    logic [CURW-1:0]       cursor_next;
    logic [CURW-1:0]       mem_ext;
    logic [CURW-1:0]       limit;
    logic                  gap_fit;
    logic                  base_match;
    logic [IW-1:0]         count_idx;

    assign rd_base     = rd_data_reg[EW-1:SIZE_W];
    assign rd_len      = rd_data_reg[SIZE_W-1:0];
    assign rd_base_ext = CURW'(rd_base);
    assign size_ext    = CURW'(size_reg);
    assign seg_end     = rd_base_ext + CURW'(rd_len);
    assign cursor_next = (seg_end > cursor_reg) ? seg_end : cursor_reg;
    assign count_idx   = count_reg[IW-1:0];

    // usable limit is the smaller of memory size and address space
    assign mem_ext = CURW'(mem_size_reg);
    assign limit   = (mem_ext < SPACE) ? mem_ext : SPACE;

    // gap in front of the segment under scan, and release match
    assign gap_fit = (rd_base_ext >= cursor_reg)
                  && ((rd_base_ext - cursor_reg) >= size_ext)
                  && ((cursor_reg + size_ext) <= limit);
    assign base_match = (rd_base_ext == CURW'(base_reg));

    // status to controller
    always_comb
    begin
        stat.is_rel   = (op_reg == OP_RELEASE);
        stat.reject   = (size_reg == '0) || (count_reg == FULL_CNT);
        stat.empty    = (count_reg == '0);
        stat.hit      = (op_reg == OP_RELEASE) ? base_match : gap_fit;
        stat.last     = ((CNTW'(idx_reg) + CNTW'(1)) == count_reg);
        stat.tail_fit = (cursor_reg <= limit) && ((limit - cursor_reg) >= size_ext);
        stat.k_at_pos = (k_reg == pos_reg);
        stat.k_at_end = ((CNTW'(k_reg) + CNTW'(1)) == count_reg);
    end

    // read address select
    always_comb
    begin
        rd_addr = '0;
        if (cmd.scan)
            rd_addr = idx_reg + IW'(1);
        else if (cmd.ins_rd)
            rd_addr = k_reg - IW'(1);
        else if (cmd.del_rd)
            rd_addr = k_reg + IW'(1);
    end

    // write port select
    always_comb
    begin
        wr_en   = cmd.ins_wr || cmd.del_wr || cmd.ins_new;
        wr_addr = cmd.ins_new ? pos_reg : k_reg;
        wr_data = cmd.ins_new ? {cursor_reg[ADDR_BITS-1:0], size_reg} : rd_data_reg;
    end

    // segment memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            seg_mem_reg[wr_addr] <= wr_data;
        rd_data_reg <= seg_mem_reg[rd_addr];
    end

    // control state: segment count and memory size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            mem_size_reg <= MEM_SIZE_RESET;
        end
        else
        begin
            if (cmd.ins_new)
                count_reg <= count_reg + CNTW'(1);
            else if (cmd.del_done)
                count_reg <= count_reg - CNTW'(1);
            if (cfg_wr_en)
                mem_size_reg <= cfg_wr_data;
        end
    end

    // working registers of the current word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_data.op;
            size_reg   <= in_data.size;
            base_reg   <= in_data.base;
            idx_reg    <= '0;
            cursor_reg <= '0;
        end
        if (cmd.scan)
        begin
            idx_reg    <= idx_reg + IW'(1);
            cursor_reg <= cursor_next;
        end
        if (cmd.set_hit)
        begin
            pos_reg <= idx_reg;
            k_reg   <= (op_reg == OP_RELEASE) ? idx_reg : count_idx;
        end
        if (cmd.set_tail)
        begin
            pos_reg <= count_idx;
            k_reg   <= count_idx;
        end
        if (cmd.ins_wr)
            k_reg <= k_reg - IW'(1);
        if (cmd.del_wr)
            k_reg <= k_reg + IW'(1);
    end

    // result and output word
    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            status_reg <= cmd.res_status;
            if (cmd.res_status != ST_OK)
                start_reg <= '0;
            else if (op_reg == OP_RELEASE)
                start_reg <= base_reg;
            else
                start_reg <= cursor_reg[START_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_data_reg.status    <= status_reg;
            out_data_reg.seg_start <= start_reg;
        end
    end

    assign out_data = out_data_reg;

endmodule

@@ rtl/core/first_fit_segment_allocator_unit.sv @@
// top level of the first-fit segment allocator: controller plus datapath
// depends on ffsa_pkg, ffsa_ctrl and ffsa_dp
//
//   channel  signals                        width  notes
//   in       in_valid, in_ready, in_data    42     op, size, base
//   out      out_valid, out_ready, out_data 22     status, seg_start
//   cfg      cfg_wr_en, cfg_wr_data         21     memory_size, no wait
//
// one word at a time: unless it is rejected or no segment exists, a word
// scans at most the segment count of slots in order until a hit or the
// last one; a placement or release then moves the later slots one by one
// to insert or close a gap, through the memory's single read and write port
// reset clears the segment count and sets memory size to 1 MiB, no sweep
// the output register lets the next word enter while a result waits; a
// result that finds the output register still full holds the block
module first_fit_segment_allocator_unit
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = FFSA_MAX_SEGMENTS,
    parameter int ADDR_BITS    = FFSA_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ffsa_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ffsa_out_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [MEM_SIZE_W-1:0] cfg_wr_data
);

    ffsa_cmd_t  cmd;
    ffsa_stat_t stat;

    // sequencing
    ffsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // segment memory and arithmetic
    ffsa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

@@ rtl/core/ffsa_checker.sv @@
// port-level checks of the first-fit segment allocator, bound to the top level
// depends on ffsa_pkg and first_fit_segment_allocator_unit_defines.svh
`include "first_fit_segment_allocator_unit_defines.svh"

module ffsa_checker
    import ffsa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input ffsa_out_t out_data
);

    // a result word stays offered until taken
    `FFSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // error results carry a zero start
    `FFSA_ASSERT_IMPL(a_err_zero, out_valid && (out_data.status != ST_OK), out_data.seg_start == '0)

    // one word in flight: busy right after an accept
    `FFSA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // a new result only comes out of a busy cycle
    `FFSA_ASSERT_IMPL(a_result_from_work, $rose(out_valid), $past(!in_ready))

endmodule

bind first_fit_segment_allocator_unit ffsa_checker u_ffsa_checker (.*);
